// ===== src/sample_histogram_binner_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the histogram binner
// Shared forms for the concurrent checks, reset gated and clocked on clk.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_BINNER_ASSERT_SVH
`define SAMPLE_HISTOGRAM_BINNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shb_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram binner package
// Widths, reset values, operation codes and shared types of the binner.
// ----------------------------------------------------------------------------
package shb_pkg;

  localparam int BIN_DEPTH_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int SAMPLE_W    = 16;
  localparam int SCALE_W     = 16;
  localparam int BINS_USE_W  = 11;
  localparam int BIN_FIELD_W = 10;
  localparam int SEL_W       = 2;
  localparam int VALUE_W     = 48;
  localparam int SUM_W       = 48;
  localparam int PROD_W      = 32;
  localparam int IDX_W       = 16;
  localparam int LIMIT_W     = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic signed [SAMPLE_W-1:0] BASE_RST     = 16'sd0;
  localparam logic [SCALE_W-1:0]         SCALE_RST    = 16'd2000;
  localparam logic [BINS_USE_W-1:0]      BINS_USE_RST = 11'd1000;

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_SAMPLE   = 2'd1,
    MODE_READ_BIN = 2'd2,
    MODE_READ_SUM = 2'd3
  } shb_mode_e;

  typedef enum logic [1:0] {
    STATUS_BINNED = 2'd0,
    STATUS_BELOW  = 2'd1,
    STATUS_ABOVE  = 2'd2,
    STATUS_NONE   = 2'd3
  } shb_status_e;

  typedef enum logic [1:0] {
    SEL_COUNT = 2'd0,
    SEL_SUM   = 2'd1,
    SEL_BELOW = 2'd2,
    SEL_ABOVE = 2'd3
  } shb_sum_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_BASE    = 2'd0,
    CFG_BIN_SCALE   = 2'd1,
    CFG_BINS_IN_USE = 2'd2
  } shb_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_UPDATE,
    ST_DONE
  } shb_state_e;

  typedef struct packed {
    logic                       clear;
    logic                       upd;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       below;
    logic                       above;
  } shb_sum_cmd_t;

  typedef struct packed {
    logic [BIN_FIELD_W-1:0]    placed;
    shb_status_e               status;
    logic signed [VALUE_W-1:0] value;
  } shb_result_t;

endpackage

// ===== src/shb_bin_ram.sv =====
// ----------------------------------------------------------------------------
// Bin count memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module shb_bin_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/shb_summary.sv =====
// ----------------------------------------------------------------------------
// Summary counters
// Sample count, saturating sample sum and the under and overflow counters.
// ----------------------------------------------------------------------------
module shb_summary
  import shb_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  shb_sum_cmd_t              cmd_i,
  input  logic [SEL_W-1:0]          sel_i,
  output logic signed [VALUE_W-1:0] value_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] below_q, below_d;
  logic [COUNT_WIDTH-1:0] above_q, above_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W:0]   sum_wide;

  assign sum_wide = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W + 1)'(cmd_i.sample);

  always_comb begin
    count_d = count_q;
    below_d = below_q;
    above_d = above_q;
    sum_d   = sum_q;
    if (cmd_i.clear) begin
      count_d = '0;
      below_d = '0;
      above_d = '0;
      sum_d   = '0;
    end else if (cmd_i.upd) begin
      count_d = (count_q == '1) ? count_q : count_q + 1'b1;
      if (cmd_i.below) begin
        below_d = (below_q == '1) ? below_q : below_q + 1'b1;
      end
      if (cmd_i.above) begin
        above_d = (above_q == '1) ? above_q : above_q + 1'b1;
      end
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        sum_d = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_d = sum_wide[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      below_q <= '0;
      above_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      below_q <= below_d;
      above_q <= above_d;
      sum_q   <= sum_d;
    end
  end

  always_comb begin
    unique case (shb_sum_sel_e'(sel_i))
      SEL_COUNT: value_o = VALUE_W'(count_q);
      SEL_SUM:   value_o = sum_q;
      SEL_BELOW: value_o = VALUE_W'(below_q);
      SEL_ABOVE: value_o = VALUE_W'(above_q);
      default:   value_o = '0;
    endcase
  end

endmodule

// ===== src/shb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Binner control and datapath
// Sequences each request through index calculation, a bin memory read and,
// for binned samples write-back, then output register; sweeps memory on clear.
// ----------------------------------------------------------------------------
module shb_ctrl
  import shb_pkg::*;
#(
  parameter int BIN_DEPTH   = BIN_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] bin_base_i,
  input  logic [SCALE_W-1:0]         bin_scale_i,
  input  logic [BINS_USE_W-1:0]      bins_in_use_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [BIN_FIELD_W-1:0]     read_bin_i,
  input  logic [SEL_W-1:0]           summary_select_i,
  output shb_sum_cmd_t               sum_cmd_o,
  output logic [SEL_W-1:0]           sum_sel_o,
  input  logic signed [VALUE_W-1:0]  sum_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output shb_result_t                result_o
);

  localparam int AW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

  shb_state_e state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          clr_pend_q, clr_pend_d;
  logic          out_valid_q, out_valid_d;

  shb_mode_e                  mode_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [BIN_FIELD_W-1:0]     read_bin_q;
  logic [SEL_W-1:0]           sel_q;
  logic                       below_q;
  logic [PROD_W-1:0]          prod_q;
  logic [IDX_W-1:0]           idx_q;
  logic [AW-1:0]              addr_q;
  logic                       binned_q;
  logic                       above_q;
  logic                       rd_ok_q;
  shb_result_t                res_q, res_d;
  shb_result_t                out_q;

  logic                       accept;
  logic                       sweep_last;
  logic                       out_free;
  logic                       load_out;
  logic                       below_c;
  logic signed [SAMPLE_W:0]   diff_wide;
  logic [PROD_W-1:0]          prod_c;
  logic [IDX_W-1:0]           idx_c;
  logic [LIMIT_W-1:0]         idx_ext;
  logic [LIMIT_W-1:0]         limit_c;
  logic [LIMIT_W-1:0]         rb_ext;
  logic                       above_c;
  logic                       rd_ok_c;
  logic [AW-1:0]              addr_c;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign sweep_last = (sweep_q == AW'(BIN_DEPTH - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_DONE) && out_free;

  assign below_c   = sample_i < bin_base_i;
  assign diff_wide = (SAMPLE_W + 1)'(sample_i) - (SAMPLE_W + 1)'(bin_base_i);
  assign prod_c    = PROD_W'(diff_wide[SAMPLE_W-1:0]) * PROD_W'(bin_scale_i);

  assign idx_c   = prod_q[PROD_W-1:PROD_W-IDX_W];
  assign idx_ext = LIMIT_W'(idx_c);
  assign limit_c = (LIMIT_W'(bins_in_use_i) > LIMIT_W'(BIN_DEPTH)) ?
                   LIMIT_W'(BIN_DEPTH) : LIMIT_W'(bins_in_use_i);
  assign above_c = idx_ext >= limit_c;
  assign rb_ext  = LIMIT_W'(read_bin_q);
  assign rd_ok_c = rb_ext < LIMIT_W'(BIN_DEPTH);
  assign addr_c  = (mode_q == MODE_SAMPLE) ? idx_ext[AW-1:0] : rb_ext[AW-1:0];

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    clr_pend_d = clr_pend_q;
    unique case (state_q)
      ST_CLEAR: begin
        sweep_d = sweep_q + 1'b1;
        if (sweep_last) begin
          sweep_d    = '0;
          clr_pend_d = 1'b0;
          state_d    = clr_pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (shb_mode_e'(mode_i) == MODE_CLEAR) begin
            state_d    = ST_CLEAR;
            sweep_d    = '0;
            clr_pend_d = 1'b1;
          end else begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = addr_q;
    ram_wdata       = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    ram_re          = 1'b0;
    sum_cmd_o       = '0;
    sum_cmd_o.sample = sample_q;
    res_d           = res_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
        if (sweep_last) begin
          res_d.placed = '0;
          res_d.status = STATUS_NONE;
          res_d.value  = '0;
        end
      end
      ST_IDLE: begin
        sum_cmd_o.clear = accept && (shb_mode_e'(mode_i) == MODE_CLEAR);
      end
      ST_CALC: begin
        ram_re          = ((mode_q == MODE_SAMPLE) && !below_q && !above_c) ||
                          ((mode_q == MODE_READ_BIN) && rd_ok_c);
        sum_cmd_o.upd   = (mode_q == MODE_SAMPLE);
        sum_cmd_o.below = below_q;
        sum_cmd_o.above = !below_q && above_c;
      end
      ST_UPDATE: begin
        res_d.placed = '0;
        res_d.status = STATUS_NONE;
        res_d.value  = '0;
        priority case (mode_q)
          MODE_SAMPLE: begin
            ram_we = binned_q;
            if (below_q) begin
              res_d.status = STATUS_BELOW;
            end else if (above_q) begin
              res_d.status = STATUS_ABOVE;
            end else begin
              res_d.status = STATUS_BINNED;
              res_d.placed = idx_q[BIN_FIELD_W-1:0];
            end
          end
          MODE_READ_BIN: begin
            res_d.value = rd_ok_q ? VALUE_W'(ram_rdata) : '0;
          end
          MODE_READ_SUM: begin
            res_d.value = sum_value_i;
          end
          default: begin
            res_d.value = '0;
          end
        endcase
      end
      ST_DONE: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= shb_mode_e'(mode_i);
      sample_q   <= sample_i;
      read_bin_q <= read_bin_i;
      sel_q      <= summary_select_i;
      below_q    <= below_c;
      prod_q     <= prod_c;
    end
    if (state_q == ST_CALC) begin
      idx_q    <= idx_c;
      addr_q   <= addr_c;
      binned_q <= (mode_q == MODE_SAMPLE) && !below_q && !above_c;
      above_q  <= above_c;
      rd_ok_q  <= rd_ok_c;
    end
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  shb_bin_ram #(
    .DEPTH (BIN_DEPTH),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_c),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign sum_sel_o   = sel_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

// ===== src/sample_histogram_binner.sv =====
// ----------------------------------------------------------------------------
// Sample histogram binner
// Fixed-width histogram of signed Q1.15 samples with summary counters.
// ----------------------------------------------------------------------------
// One request is handled at a time. An add, read-bin or read-summary request
// passes, from acceptance until the next request can be accepted, through the
// index multiply, the bin memory read, the write-back of the incremented count
// for a binned add and the load of the output register, which waits while the
// output side stalls. A clear request, and the clearing pass that follows
// reset, sweep the bin memory one entry per cycle while no request is
// accepted; configuration writes are taken at any time. The result register
// holds a finished result while the output side stalls.
module sample_histogram_binner
  import shb_pkg::*;
#(
  parameter int BIN_DEPTH   = BIN_DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [BIN_FIELD_W-1:0]     read_bin_i,
  input  logic [SEL_W-1:0]           summary_select_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [BIN_FIELD_W-1:0]     placed_bin_o,
  output logic [1:0]                 place_status_o,
  output logic signed [VALUE_W-1:0]  read_value_o
);

  logic signed [SAMPLE_W-1:0] bin_base_q;
  logic [SCALE_W-1:0]         bin_scale_q;
  logic [BINS_USE_W-1:0]      bins_in_use_q;
  logic                       cfg_we;

  shb_sum_cmd_t              sum_cmd;
  logic [SEL_W-1:0]          sum_sel;
  logic signed [VALUE_W-1:0] sum_value;
  shb_result_t               result;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_base_q    <= BASE_RST;
      bin_scale_q   <= SCALE_RST;
      bins_in_use_q <= BINS_USE_RST;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_BIN_BASE) begin
        bin_base_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_BIN_SCALE) begin
        bin_scale_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_BINS_IN_USE) begin
        bins_in_use_q <= cfg_data_i[BINS_USE_W-1:0];
      end
    end
  end

  shb_ctrl #(
    .BIN_DEPTH   (BIN_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bin_base_i       (bin_base_q),
    .bin_scale_i      (bin_scale_q),
    .bins_in_use_i    (bins_in_use_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .sample_i         (sample_i),
    .read_bin_i       (read_bin_i),
    .summary_select_i (summary_select_i),
    .sum_cmd_o        (sum_cmd),
    .sum_sel_o        (sum_sel),
    .sum_value_i      (sum_value),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_o         (result)
  );

  shb_summary #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_summary (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (sum_cmd),
    .sel_i   (sum_sel),
    .value_o (sum_value)
  );

  assign placed_bin_o   = result.placed;
  assign place_status_o = result.status;
  assign read_value_o   = result.value;

endmodule

// ===== src/shb_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram binner port checker
// Checks the result channel and request sequencing seen at the top level.
// ----------------------------------------------------------------------------
`include "sample_histogram_binner_assert.svh"

module shb_checker
  import shb_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [BIN_FIELD_W-1:0]     placed_bin_o,
  input logic [1:0]                 place_status_o,
  input logic signed [VALUE_W-1:0]  read_value_o
);

  `SHB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(placed_bin_o) && $stable(place_status_o) && $stable(read_value_o), "stalled result changed")

  `SHB_ASSERT_NEXT(a_one_request, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "second request accepted while one is in flight")

  `SHB_ASSERT_NOW(a_placed_zero, clk_i, rst_ni, out_valid_o && place_status_o != STATUS_BINNED, placed_bin_o == '0, "placed bin set on a result that was not binned")

  `SHB_ASSERT_NOW(a_value_zero, clk_i, rst_ni, out_valid_o && place_status_o != STATUS_NONE, read_value_o == '0, "read value set on a sample result")

endmodule

bind sample_histogram_binner shb_checker u_shb_checker (.*);
